>>> rtl/open_address_hash_table_assert.svh
// Assertion macros shared by the hash table RTL.
// Needs clk and rst_n in the including module's scope.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/oaht_pkg.sv
// Shared types, codes and defaults for the open-addressing hash table.
// No dependencies.
package oaht_pkg;

    localparam int TABLE_DEPTH_DEF  = 1024;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int SLOT_W = 11;
    localparam int KEY_W  = 64;

    // request kinds
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_LOOKUP  = 2'd1;
    localparam logic [1:0] KIND_DELETE  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // response status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // slot states
    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_USED = 2'd1;
    localparam logic [1:0] SLOT_GONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TABLE_SIZE   = 2'd0;
    localparam logic [1:0] CFG_PROBE_OFFSET = 2'd1;
    localparam logic [1:0] CFG_PROBE_PRIME  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] attempt;
    } probe_cmd_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } probe_rsp_t;

endpackage

>>> rtl/oaht_slot_ram.sv
// Slot store: one synchronous RAM, one write and one read port, registered read.
// Uses no package items.
module oaht_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 98
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/oaht_probe_addr.sv
// Probe address unit: slot = (key + i*i*((key/(i+off)) mod prime)) mod size.
// Bit-serial divide with running mod-prime, then multiply, add, nibble-serial mod.
// Depends on oaht_pkg.
module oaht_probe_addr (
    input  logic                        clk,
    input  logic                        rst_n,
    input  oaht_pkg::probe_cmd_t        cmd,
    input  logic [oaht_pkg::KEY_W-1:0]  key,
    input  logic [15:0]                 offset,
    input  logic [15:0]                 prime,
    input  logic [oaht_pkg::SLOT_W-1:0] size,
    output oaht_pkg::probe_rsp_t        rsp
);

    typedef enum logic [2:0] {P_IDLE, P_DIV, P_MUL, P_ADD, P_MOD} pstate_t;

    pstate_t                     state_reg;
    logic                        done_reg;
    logic [16:0]                 d_reg;
    logic [16:0]                 rem_reg;
    logic [15:0]                 r2_reg;
    logic [5:0]                  bit_reg;
    logic [21:0]                 sq_reg;
    logic [37:0]                 prod_reg;
    logic [63:0]                 sum_reg;
    logic [oaht_pkg::SLOT_W-1:0] mr_reg;
    logic [3:0]                  nib_reg;

    logic [17:0]                 rem_sh;
    logic [16:0]                 rem_next;
    logic                        qbit;
    logic [16:0]                 r2_sh;
    logic [15:0]                 r2_next;
    logic [oaht_pkg::SLOT_W-1:0] mr_next;
    logic [oaht_pkg::SLOT_W:0]   mt;

    // one quotient bit per cycle; quotient mod prime tracked as bits appear
    always_comb
    begin
        rem_sh = {rem_reg, key[bit_reg]};
        if (rem_sh >= {1'b0, d_reg})
        begin
            rem_next = 17'(rem_sh - {1'b0, d_reg});
            qbit     = 1'b1;
        end
        else
        begin
            rem_next = rem_sh[16:0];
            qbit     = 1'b0;
        end
        r2_sh = {r2_reg, qbit};
        if (r2_sh >= {1'b0, prime})
        begin
            r2_next = 16'(r2_sh - {1'b0, prime});
        end
        else
        begin
            r2_next = r2_sh[15:0];
        end
    end

    // four bits of the sum per cycle into the running mod-size remainder
    always_comb
    begin
        mr_next = mr_reg;
        mt      = '0;
        for (int j = 0; j < 4; j++)
        begin
            mt = {mr_next, sum_reg[63-j]};
            if (mt >= {1'b0, size})
            begin
                mt = mt - {1'b0, size};
            end
            mr_next = mt[oaht_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                P_IDLE:
                begin
                    if (cmd.start)
                    begin
                        sq_reg  <= 22'(cmd.attempt) * 22'(cmd.attempt);
                        d_reg   <= 17'(cmd.attempt) + 17'(offset);
                        rem_reg <= '0;
                        r2_reg  <= '0;
                        bit_reg <= 6'd63;
                        // probe zero has no step term
                        state_reg <= (cmd.attempt == '0) ? P_MUL : P_DIV;
                    end
                end
                P_DIV:
                begin
                    rem_reg <= rem_next;
                    r2_reg  <= r2_next;
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == '0)
                    begin
                        state_reg <= P_MUL;
                    end
                end
                P_MUL:
                begin
                    prod_reg  <= 38'(sq_reg) * 38'(r2_reg);
                    state_reg <= P_ADD;
                end
                P_ADD:
                begin
                    sum_reg   <= key + 64'(prod_reg);
                    mr_reg    <= '0;
                    nib_reg   <= '0;
                    state_reg <= P_MOD;
                end
                P_MOD:
                begin
                    mr_reg  <= mr_next;
                    sum_reg <= {sum_reg[59:0], 4'b0};
                    nib_reg <= nib_reg + 4'd1;
                    if (nib_reg == 4'hF)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.slot = mr_reg;

endmodule

>>> rtl/open_address_hash_table.sv
// Open-addressing hash table with tombstones: insert, lookup and delete of 64-bit keys.
// One request is in work at a time. Probe 0 skips the bit-serial key division; every further
// probe runs it, then the multiply, the add, the nibble-serial mod-size reduction and one RAM
// read. After reset the slot RAM is swept to free, one slot a cycle; no request is taken
// meanwhile, config writes are.
// Depends on oaht_pkg, oaht_probe_addr, oaht_slot_ram and open_address_hash_table_assert.svh.
module open_address_hash_table #(
    parameter int TABLE_DEPTH  = oaht_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = oaht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key[63:0], payload_in[95:64]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // payload_out[31:0], probes[42:32], occupied_count[53:43],
                                    // max_probes[64:54], zero[71:65]
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = oaht_pkg::SLOT_W;
    localparam int WW = 2 + oaht_pkg::KEY_W + PAYLOAD_BITS;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ADDR, S_CHECK, S_RESP} state_t;

    state_t                  state_reg;
    logic [AW-1:0]           clr_idx_reg;
    logic [SW-1:0]           table_size_reg;
    logic [15:0]             probe_offset_reg;
    logic [15:0]             probe_prime_reg;
    logic [1:0]              kind_reg;
    logic [63:0]             key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [SW-1:0]           tries_reg;
    logic [SW-1:0]           count_reg;
    logic [SW-1:0]           worst_reg;
    logic [SW-1:0]           slot_reg;
    logic [1:0]              res_status_reg;
    logic [31:0]             res_pout_reg;
    logic                    m_tvalid_reg;
    logic [71:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic [SW-1:0]           size_eff;
    logic [15:0]             offset_eff;
    logic [15:0]             prime_eff;
    oaht_pkg::probe_cmd_t    probe_cmd;
    oaht_pkg::probe_rsp_t    probe_rsp;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [WW-1:0]           mem_wdata;
    logic [WW-1:0]           mem_rdata;
    logic [1:0]              rd_status;
    logic [63:0]             rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [SW:0]             tries_inc;
    logic                    accept;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = SW'(1);
        end
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            size_eff = SW'(TABLE_DEPTH);
        end
        else
        begin
            size_eff = table_size_reg;
        end
        offset_eff = (probe_offset_reg == '0) ? 16'd1 : probe_offset_reg;
        prime_eff  = (probe_prime_reg == '0) ? 16'd1 : probe_prime_reg;
    end

    assign rd_status = mem_rdata[WW-1 -: 2];
    assign rd_key    = mem_rdata[PAYLOAD_BITS +: 64];
    assign rd_pay    = mem_rdata[PAYLOAD_BITS-1:0];
    assign tries_inc = {1'b0, tries_reg} + 1'b1;

    always_comb
    begin
        probe_cmd.start   = 1'b0;
        probe_cmd.attempt = '0;
        if (state_reg == S_IDLE && accept && s_tuser != oaht_pkg::KIND_UNKNOWN)
        begin
            probe_cmd.start = 1'b1;
        end
        else if (state_reg == S_CHECK && tries_inc < {1'b0, size_eff})
        begin
            // continue only when this slot did not end the search
            if ((kind_reg == oaht_pkg::KIND_INSERT && rd_status == oaht_pkg::SLOT_USED) ||
                (kind_reg != oaht_pkg::KIND_INSERT && rd_status != oaht_pkg::SLOT_FREE &&
                 !(rd_status == oaht_pkg::SLOT_USED && rd_key == key_reg)))
            begin
                probe_cmd.start   = 1'b1;
                probe_cmd.attempt = tries_inc[SW-1:0];
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(slot_reg);
        mem_wdata = {oaht_pkg::SLOT_USED, key_reg, pay_reg};
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_CHECK)
        begin
            if (kind_reg == oaht_pkg::KIND_INSERT)
            begin
                mem_we = (rd_status != oaht_pkg::SLOT_USED);
            end
            else if (kind_reg == oaht_pkg::KIND_DELETE &&
                     rd_status == oaht_pkg::SLOT_USED && rd_key == key_reg)
            begin
                mem_we    = 1'b1;
                mem_wdata = {oaht_pkg::SLOT_GONE, rd_key, rd_pay};
            end
        end
    end

    oaht_probe_addr u_probe (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (probe_cmd),
        .key    (key_reg),
        .offset (offset_eff),
        .prime  (prime_eff),
        .size   (size_eff),
        .rsp    (probe_rsp)
    );

    oaht_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (probe_rsp.done),
        .raddr (AW'(probe_rsp.slot)),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            table_size_reg   <= SW'(1024);
            probe_offset_reg <= 16'd1;
            probe_prime_reg  <= 16'd7;
            count_reg        <= '0;
            worst_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    oaht_pkg::CFG_TABLE_SIZE:   table_size_reg   <= cfg_data[SW-1:0];
                    oaht_pkg::CFG_PROBE_OFFSET: probe_offset_reg <= cfg_data;
                    oaht_pkg::CFG_PROBE_PRIME:  probe_prime_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
            // S_RESP drives the valid flag itself
            if (m_tready && state_reg != S_RESP)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg       <= s_tuser;
                        key_reg        <= s_tdata[63:0];
                        pay_reg        <= PAYLOAD_BITS'(s_tdata[95:64]);
                        tries_reg      <= '0;
                        res_pout_reg   <= '0;
                        res_status_reg <= oaht_pkg::ST_NOTFOUND;
                        state_reg      <= (s_tuser == oaht_pkg::KIND_UNKNOWN) ? S_RESP : S_ADDR;
                    end
                end
                S_ADDR:
                begin
                    if (probe_rsp.done)
                    begin
                        slot_reg  <= probe_rsp.slot;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (probe_cmd.start)
                    begin
                        tries_reg <= tries_inc[SW-1:0];
                        state_reg <= S_ADDR;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                        if (kind_reg == oaht_pkg::KIND_INSERT)
                        begin
                            if (rd_status != oaht_pkg::SLOT_USED)
                            begin
                                res_status_reg <= oaht_pkg::ST_OK;
                                count_reg      <= count_reg + 1'b1;
                                if (tries_reg > worst_reg)
                                begin
                                    worst_reg <= tries_reg;
                                end
                            end
                            else
                            begin
                                res_status_reg <= oaht_pkg::ST_FULL;
                                tries_reg      <= size_eff;
                            end
                        end
                        else if (rd_status == oaht_pkg::SLOT_USED && rd_key == key_reg)
                        begin
                            res_status_reg <= oaht_pkg::ST_OK;
                            if (kind_reg == oaht_pkg::KIND_LOOKUP)
                            begin
                                res_pout_reg <= 32'(rd_pay);
                            end
                            else
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        else if (rd_status != oaht_pkg::SLOT_FREE)
                        begin
                            // every slot visited without a free slot or a match
                            tries_reg <= size_eff;
                        end
                    end
                end
                S_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {7'b0, worst_reg, count_reg, tries_reg, res_pout_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "open_address_hash_table_assert.svh"

    `OAHT_ASSERT_NEXT(a_one_request, accept, !s_tready, "request taken while one is in work")
    `OAHT_ASSERT_NOW(a_done_in_addr, probe_rsp.done, state_reg == S_ADDR, "stray probe result")
    `OAHT_ASSERT_NOW(a_tries_range, state_reg == S_CHECK, tries_reg < size_eff, "bad tries")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for open_address_hash_table: a directed table, then random phases.
// Requests are predicted by a local model of the probe sequence; depends on oaht_pkg and the RTL.
module tb_top;

    localparam int DEPTH = 1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] payload;
        logic [10:0] probes;
        logic [10:0] occupied;
        logic [10:0] worst;
    } oaht_result_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  kind;      // register index on config rows
        logic [63:0] key;       // register value on config rows
        logic [31:0] payload;
        bit          typed;
        oaht_result_t want;
    } step_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // key[63:0], payload_in[95:64]
    logic [1:0]   s_tuser;   // kind[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // payload_out[31:0], probes[42:32], occupied_count[53:43],
                             // max_probes[64:54]
    logic [1:0]   m_tuser;   // status[1:0]
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    open_address_hash_table u_top (.*);

    // table shadow
    logic [1:0]   slot_state [DEPTH];
    logic [63:0]  slot_k     [DEPTH];
    logic [31:0]  slot_p     [DEPTH];
    int unsigned  live_count;
    int unsigned  worst_seen;
    logic [10:0]  size_reg;
    logic [15:0]  offset_reg;
    logic [15:0]  prime_reg;

    oaht_result_t answers_due[$];
    step_row_t    steps[$];
    int           errors;
    bit           quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #500_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned probe_slot(logic [63:0] key, int unsigned attempt,
                                               int unsigned size);
        logic [63:0] off;
        logic [63:0] prm;
        logic [63:0] sq;
        logic [63:0] step;
        logic [63:0] addr;
        off  = (offset_reg == 0) ? 64'd1 : 64'(offset_reg);
        prm  = (prime_reg == 0) ? 64'd1 : 64'(prime_reg);
        sq   = 64'(attempt) * 64'(attempt);
        step = (key / (64'(attempt) + off)) % prm;
        addr = key + sq * step;
        return int'(addr % 64'(size));
    endfunction

    function automatic oaht_result_t apply_request(logic [1:0] kind, logic [63:0] key,
                                                   logic [31:0] pay);
        oaht_result_t r;
        int unsigned size;
        int unsigned tries;
        int unsigned slot;
        size  = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
        tries = 0;
        r.status  = oaht_pkg::ST_NOTFOUND;
        r.payload = '0;
        if (kind == oaht_pkg::KIND_INSERT)
        begin
            slot = probe_slot(key, 0, size);
            while (tries < size && slot_state[slot] == oaht_pkg::SLOT_USED)
            begin
                tries++;
                slot = probe_slot(key, tries, size);
            end
            if (tries >= size)
                r.status = oaht_pkg::ST_FULL;
            else
            begin
                slot_state[slot] = oaht_pkg::SLOT_USED;
                slot_k[slot] = key;
                slot_p[slot] = pay;
                live_count++;
                if (tries > worst_seen)
                    worst_seen = tries;
                r.status = oaht_pkg::ST_OK;
            end
        end
        else if (kind == oaht_pkg::KIND_LOOKUP || kind == oaht_pkg::KIND_DELETE)
        begin
            slot = probe_slot(key, 0, size);
            while (tries < size && slot_state[slot] != oaht_pkg::SLOT_FREE)
            begin
                if (slot_state[slot] == oaht_pkg::SLOT_USED && slot_k[slot] == key)
                begin
                    if (kind == oaht_pkg::KIND_LOOKUP)
                        r.payload = slot_p[slot];
                    else
                    begin
                        slot_state[slot] = oaht_pkg::SLOT_GONE;
                        live_count--;
                    end
                    r.status = oaht_pkg::ST_OK;
                    break;
                end
                tries++;
                slot = probe_slot(key, tries, size);
            end
        end
        r.probes   = tries[10:0];
        r.occupied = live_count[10:0];
        r.worst    = worst_seen[10:0];
        return r;
    endfunction

    // response checker
    always @(posedge clk)
    begin
        oaht_result_t got;
        oaht_result_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status   = m_tuser;
            got.payload  = m_tdata[31:0];
            got.probes   = m_tdata[42:32];
            got.occupied = m_tdata[53:43];
            got.worst    = m_tdata[64:54];
            if (answers_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response: st=%0d pay=%h", got.status, got.payload);
            end
            else
            begin
                w = answers_due.pop_front();
                if (got != w)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: want st=%0d pay=%h pr=%0d occ=%0d max=%0d",
                                 w.status, w.payload, w.probes, w.occupied, w.worst);
                        $display("          got  st=%0d pay=%h pr=%0d occ=%0d max=%0d",
                                 got.status, got.payload, got.probes, got.occupied,
                                 got.worst);
                    end
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_request(logic [1:0] kind, logic [63:0] key, logic [31:0] pay,
                                bit typed, oaht_result_t want);
        oaht_result_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tdata  = {pay, key};
        s_tuser  = kind;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        r = apply_request(kind, key, pay);
        answers_due.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // let every outstanding response come back before touching registers
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        s_tvalid = 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == oaht_pkg::CFG_TABLE_SIZE)
            size_reg = value[10:0];
        else if (idx == oaht_pkg::CFG_PROBE_OFFSET)
            offset_reg = value;
        else if (idx == oaht_pkg::CFG_PROBE_PRIME)
            prime_reg = value;
    endtask

    task automatic add_row(bit is_cfg, logic [1:0] kind, logic [63:0] key,
                           logic [31:0] pay, bit typed, logic [1:0] st, logic [31:0] pout,
                           logic [10:0] pr, logic [10:0] occ, logic [10:0] mx);
        step_row_t row;
        row.is_cfg  = is_cfg;
        row.kind    = kind;
        row.key     = key;
        row.payload = pay;
        row.typed   = typed;
        row.want    = '{st, pout, pr, occ, mx};
        steps.push_back(row);
    endtask

    initial
    begin
        logic [63:0] pool[16];
        logic [1:0]  kind;
        logic [63:0] key;
        int          pick;
        oaht_result_t none;

        none = '{default: '0};
        errors = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (slot_state[i])
        begin
            slot_state[i] = oaht_pkg::SLOT_FREE;
            slot_k[i] = '0;
            slot_p[i] = '0;
        end
        live_count = 0;
        worst_seen = 0;
        size_reg   = 11'd1024;
        offset_reg = 16'd1;
        prime_reg  = 16'd7;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset values, key and payload extremes, every kind
        add_row(0, oaht_pkg::KIND_LOOKUP, 64'd0, 32'd0, 1, oaht_pkg::ST_NOTFOUND, 32'd0,
                11'd0, 11'd0, 11'd0);
        add_row(0, oaht_pkg::KIND_INSERT, 64'd0, '1, 1, oaht_pkg::ST_OK, 32'd0,
                11'd0, 11'd1, 11'd0);
        add_row(0, oaht_pkg::KIND_LOOKUP, 64'd0, 32'd0, 1, oaht_pkg::ST_OK, '1,
                11'd0, 11'd1, 11'd0);
        add_row(0, oaht_pkg::KIND_INSERT, '1, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_INSERT, 64'd0, 32'h5a5a_5a5a, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_LOOKUP, '1, 32'hffff_0000, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_DELETE, 64'd0, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_LOOKUP, 64'd0, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_UNKNOWN, 64'h8000_0000_0000_0001, '1, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_DELETE, 64'd12345, 32'd0, 0, 0, 0, 0, 0, 0);
        // tiny table with zero offset and zero prime: every probe hits one slot
        add_row(1, oaht_pkg::CFG_TABLE_SIZE, 64'd4, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, oaht_pkg::CFG_PROBE_OFFSET, 64'd0, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, oaht_pkg::CFG_PROBE_PRIME, 64'd0, 0, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 3; k++)
            add_row(0, oaht_pkg::KIND_INSERT, 64'(k + 8), 32'(k), 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_LOOKUP, 64'd77, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_DELETE, 64'd8, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_INSERT, 64'd16, 32'hdead_beef, 0, 0, 0, 0, 0, 0);
        add_row(1, oaht_pkg::CFG_TABLE_SIZE, 64'd0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_INSERT, 64'd3, 32'd3, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_INSERT, 64'd5, 32'd5, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_LOOKUP, 64'd5, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(1, oaht_pkg::CFG_TABLE_SIZE, 64'd2047, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, oaht_pkg::CFG_PROBE_OFFSET, 64'd65535, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, oaht_pkg::CFG_PROBE_PRIME, 64'd65535, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_LOOKUP, '1, 32'd0, 0, 0, 0, 0, 0, 0);
        add_row(0, oaht_pkg::KIND_INSERT, 64'hffff_ffff_ffff_fffe, 32'h1234_5678,
                0, 0, 0, 0, 0, 0);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                write_reg(steps[i].kind, steps[i].key[15:0]);
            else
                send_request(steps[i].kind, steps[i].key, steps[i].payload,
                             steps[i].typed, steps[i].want);
        end

        // random phases, mostly small tables so searches stay short
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(oaht_pkg::CFG_TABLE_SIZE,
                      (ph == 9) ? 16'd64 : 16'($urandom_range(2, 20)));
            write_reg(oaht_pkg::CFG_PROBE_OFFSET, ($urandom_range(0, 3) == 0) ?
                      16'($urandom_range(0, 1) * 65535) : 16'($urandom_range(1, 40)));
            write_reg(oaht_pkg::CFG_PROBE_PRIME, ($urandom_range(0, 3) == 0) ?
                      16'($urandom) : 16'($urandom_range(0, 13)));
            foreach (pool[i])
                pool[i] = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 1)) * '1
                          : {$urandom, $urandom};
            if (ph == 9)
                quiet = 1'b1;
            for (int n = 0; n < 200; n++)
            begin
                pick = $urandom_range(0, 99);
                kind = (pick < 40) ? oaht_pkg::KIND_INSERT :
                       (pick < 72) ? oaht_pkg::KIND_LOOKUP :
                       (pick < 96) ? oaht_pkg::KIND_DELETE : oaht_pkg::KIND_UNKNOWN;
                key = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                      : pool[$urandom_range(0, 15)];
                send_request(kind, key, $urandom, 0, none);
            end
        end

        s_tvalid = 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && answers_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/oaht_pkg.sv
rtl/oaht_slot_ram.sv
rtl/oaht_probe_addr.sv
rtl/open_address_hash_table.sv
dv/tb_top.sv
